### rtl/core/dq_pkg.sv
// Shared constants, types and codes for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int unsigned Depth      = 64;
  localparam int unsigned ItemWidth  = 32;
  localparam int unsigned CountWidth = $clog2(Depth + 1);
  localparam int unsigned GroupSize  = 8;
  localparam int unsigned NumGroups  = Depth / GroupSize;

  typedef logic [ItemWidth-1:0]  item_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_BACK   = 2'd2,
    FUNC_POP_FRONT  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TREE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/dq_cell.sv
// One storage cell of the queue row: item register, occupancy bit, tail tap.
`default_nettype none

module dq_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dq_pkg::cell_ctrl_t ctrl_i,
  input  wire dq_pkg::item_t     item_i,
  input  wire dq_pkg::item_t     left_data_i,
  input  wire logic              left_valid_i,
  input  wire dq_pkg::item_t     right_data_i,
  input  wire logic              right_valid_i,
  output dq_pkg::item_t          data_o,
  output logic                   valid_o,
  output dq_pkg::item_t          tail_data_o
);

  dq_pkg::item_t data_q, data_d;
  logic          valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctrl_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.push_back) begin
      // first free cell takes the item
      if (!valid_q && left_valid_i) begin
        data_d = item_i;
      end
      valid_d = left_valid_i;
    end else if (ctrl_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.pop_back) begin
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign tail_data_o = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

`default_nettype wire

### rtl/core/dq_gather.sv
// Registered OR tree that collects the tail cell's item from the row.
`default_nettype none

module dq_gather (
  input  wire logic          clk_i,
  input  wire dq_pkg::item_t tail_data_i [dq_pkg::Depth],
  output dq_pkg::item_t      back_value_o
);

  dq_pkg::item_t group_q [dq_pkg::NumGroups];
  dq_pkg::item_t group_d [dq_pkg::NumGroups];

  always_comb begin
    for (int g = 0; g < int'(dq_pkg::NumGroups); g++) begin
      group_d[g] = '0;
      for (int k = 0; k < int'(dq_pkg::GroupSize); k++) begin
        group_d[g] = group_d[g] | tail_data_i[g * int'(dq_pkg::GroupSize) + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < int'(dq_pkg::NumGroups); g++) begin
      group_q[g] <= group_d[g];
    end
  end

  always_comb begin
    back_value_o = '0;
    for (int g = 0; g < int'(dq_pkg::NumGroups); g++) begin
      back_value_o = back_value_o | group_q[g];
    end
  end

endmodule

`default_nettype wire

### rtl/core/double_ended_queue.sv
// Top level of the double-ended queue: control, cell row and result register.
//
// Usage: one request channel (func_i, item_value_i) and one result channel
// (popped_value_o, status_o, item_count_o, front_value_o, back_value_o),
// both valid/ready. Every request transfer yields exactly one result.
// Items sit packed in a row of 64 cells, front in cell 0; a push front or
// pop front shifts the whole row by one cell, a push back writes the first
// free cell, a pop back clears the tail occupancy bit.
// A new request is taken only once the result of the previous one is in the
// output register; the row is updated when the request is taken, and the
// two-level OR tree then finds the new back item for the result.
// A push to a full queue is dropped with status 2, a pop on an empty queue
// returns zero with status 1; neither changes the contents.
// Reset empties the queue at once (occupancy bits clear, count zero).
// The result is held in an output register; while the receiver stalls, the
// next request is still taken and worked on, and it waits in its last step
// until the output register frees up.
`default_nettype none

module double_ended_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] item_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      popped_value_o,
  output logic [1:0]       status_o,
  output logic [6:0]       item_count_o,
  output logic [31:0]      front_value_o,
  output logic [31:0]      back_value_o
);

  dq_pkg::state_e     state_q, state_d;
  dq_pkg::count_t     count_q, count_d;
  dq_pkg::item_t      back_q;
  dq_pkg::item_t      popped_q, popped_d;
  dq_pkg::status_e    status_q, status_d;
  dq_pkg::cell_ctrl_t ctrl;
  logic               accept;
  logic               load;
  logic               full;
  logic               empty;
  dq_pkg::item_t      gathered;

  dq_pkg::item_t cell_data [dq_pkg::Depth];
  logic          cell_valid [dq_pkg::Depth];
  dq_pkg::item_t tail_data [dq_pkg::Depth];

  logic               out_valid_q;
  dq_pkg::item_t      out_popped_q;
  dq_pkg::status_e    out_status_q;
  dq_pkg::count_t     out_count_q;
  dq_pkg::item_t      out_front_q;
  dq_pkg::item_t      out_back_q;

  assign accept = in_valid_i && in_ready_o;
  assign full   = (count_q == dq_pkg::CountWidth'(dq_pkg::Depth));
  assign empty  = (count_q == '0);

  // request decode
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = status_q;
    popped_d = popped_q;
    if (accept) begin
      status_d = dq_pkg::STATUS_OK;
      popped_d = '0;
      unique case (dq_pkg::func_e'(func_i))
        dq_pkg::FUNC_PUSH_BACK: begin
          if (full) begin
            status_d = dq_pkg::STATUS_FULL;
          end else begin
            ctrl.push_back = 1'b1;
            count_d        = count_q + 1'b1;
          end
        end
        dq_pkg::FUNC_PUSH_FRONT: begin
          if (full) begin
            status_d = dq_pkg::STATUS_FULL;
          end else begin
            ctrl.push_front = 1'b1;
            count_d         = count_q + 1'b1;
          end
        end
        dq_pkg::FUNC_POP_BACK: begin
          if (empty) begin
            status_d = dq_pkg::STATUS_EMPTY;
          end else begin
            ctrl.pop_back = 1'b1;
            popped_d      = back_q;
            count_d       = count_q - 1'b1;
          end
        end
        dq_pkg::FUNC_POP_FRONT: begin
          if (empty) begin
            status_d = dq_pkg::STATUS_EMPTY;
          end else begin
            ctrl.pop_front = 1'b1;
            popped_d       = cell_data[0];
            count_d        = count_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // cell row
  for (genvar i = 0; i < int'(dq_pkg::Depth); i++) begin : g_cell
    dq_pkg::item_t left_data;
    logic          left_valid;
    dq_pkg::item_t right_data;
    logic          right_valid;

    if (i == 0) begin : g_head
      assign left_data  = item_value_i;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == int'(dq_pkg::Depth) - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .item_i        (item_value_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .tail_data_o   (tail_data[i])
    );
  end

  dq_gather u_gather (
    .clk_i        (clk_i),
    .tail_data_i  (tail_data),
    .back_value_o (gathered)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dq_pkg::ST_IDLE: if (accept) state_d = dq_pkg::ST_TREE;
      dq_pkg::ST_TREE: state_d = dq_pkg::ST_DONE;
      dq_pkg::ST_DONE: if (load) state_d = dq_pkg::ST_IDLE;
      default:         state_d = dq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    unique case (state_q)
      dq_pkg::ST_IDLE: in_ready_o = 1'b1;
      dq_pkg::ST_TREE: ;
      dq_pkg::ST_DONE: load = !out_valid_q || out_ready_i;
      default:         ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      count_q     <= '0;
      back_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        back_q      <= gathered;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
    if (load) begin
      out_popped_q <= popped_q;
      out_status_q <= status_q;
      out_count_q  <= count_q;
      out_front_q  <= empty ? '0 : cell_data[0];
      out_back_q   <= gathered;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_popped_q;
  assign status_o       = out_status_q;
  assign item_count_o   = out_count_q;
  assign front_value_o  = out_front_q;
  assign back_value_o   = out_back_q;

endmodule

`default_nettype wire
